// ===== design/ofr_pkg.sv =====
// ----------------------------------------------------------------------------
// ofr_pkg: shared types and constants of the orthonormal frame unit
// Word layouts of both channels, the inner column word and its metadata,
// datapath widths and the column select codes.
// ----------------------------------------------------------------------------
package ofr_pkg;

   localparam int FRAC_BITS_DEF = 16;

   // point and vector widths
   localparam int PT_W   = 32;
   localparam int DIF_W  = PT_W + 1;        // b-a, c-a
   localparam int Z_W    = 2 * DIF_W + 1;   // x cross y0
   localparam int ZL_W   = 34;              // unsigned low part of z
   localparam int ZH_W   = Z_W - ZL_W;      // signed high part of z
   localparam int T_W    = 101;             // signed axis component
   localparam int MAG_W  = 100;             // axis component magnitude

   // squaring datapath
   localparam int CH_W   = 25;
   localparam int N_CH   = MAG_W / CH_W;
   localparam int PP_W   = 2 * CH_W;
   localparam int ROW_W  = CH_W * (N_CH + 1) + 2;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int S_W    = SQ_W + 2;

   // centroid: divide by three through a reciprocal
   localparam int CSUM_W = PT_W + 2;
   localparam int CN_W   = 34;
   localparam int CEN_K  = 35;
   localparam logic [CN_W-1:0] CEN_M = 34'h2AAAAAAAB;

   // column select codes
   localparam logic [1:0] COL_X   = 2'd0;
   localparam logic [1:0] COL_Y   = 2'd1;
   localparam logic [1:0] COL_Z   = 2'd2;
   localparam logic [1:0] COL_CEN = 2'd3;

   typedef struct packed {
      logic signed [PT_W-1:0] a_x;
      logic signed [PT_W-1:0] a_y;
      logic signed [PT_W-1:0] a_z;
      logic signed [PT_W-1:0] b_x;
      logic signed [PT_W-1:0] b_y;
      logic signed [PT_W-1:0] b_z;
      logic signed [PT_W-1:0] c_x;
      logic signed [PT_W-1:0] c_y;
      logic signed [PT_W-1:0] c_z;
   } req_word_type;

   typedef struct packed {
      logic [1:0]             column_sel;
      logic signed [PT_W-1:0] vec_x;
      logic signed [PT_W-1:0] vec_y;
      logic signed [PT_W-1:0] vec_z;
      logic                   ok;
      logic                   last;
   } rsp_word_type;

   // one column as issued by the sequencer
   typedef struct packed {
      logic [1:0]                sel;
      logic                      deg;
      logic                      cen;
      logic                      lst;
      logic [2:0][T_W-1:0]       val;
   } col_word_type;

   typedef struct packed {
      logic [1:0]                sel;
      logic                      deg;
      logic                      cen;
      logic                      lst;
      logic [2:0]                neg;
      logic [2:0][PT_W-1:0]      cval;
   } col_meta_type;

   typedef struct packed {
      col_meta_type              meta;
      logic [2:0][SQ_W-1:0]      sq;
   } sq_word_type;

endpackage

// ===== design/ofr_front.sv =====
// ----------------------------------------------------------------------------
// ofr_front: axis vectors, centroid and column sequencer
// Five stages form x = b-a, y0 = c-a, z = x cross y0, y = z cross x and the
// rounded centroid; the last stage issues one column word a cycle unless held.
// ----------------------------------------------------------------------------
module ofr_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  ofr_pkg::req_word_type in_data,
   output logic                 out_valid,
   input  logic                 out_stall,
   output ofr_pkg::col_word_type out_data
);
   import ofr_pkg::*;

   localparam int NST = 5;

   logic [NST-1:0] vld_ff;
   logic [NST-1:0] go;
   logic [1:0]     cnt_ff;
   logic [1:0]     cnt_in;
   logic           take;
   logic           release_w;

   // stage 1
   logic signed [DIF_W-1:0]   x1_ff [3];
   logic signed [DIF_W-1:0]   y1_ff [3];
   logic signed [CSUM_W-1:0]  cs1_ff [3];
   // stage 2
   logic signed [DIF_W-1:0]   x2_ff [3];
   logic signed [2*DIF_W-1:0] pa2_ff [3];
   logic signed [2*DIF_W-1:0] pb2_ff [3];
   logic [CN_W-1:0]           cn2_ff [3];
   logic [2:0]                cneg2_ff;
   // stage 3
   logic signed [DIF_W-1:0]   x3_ff [3];
   logic signed [Z_W-1:0]     z3_ff [3];
   logic [PT_W-1:0]           cq3_ff [3];
   logic [2:0]                cneg3_ff;
   // stage 4
   logic signed [DIF_W-1:0]       x4_ff [3];
   logic signed [Z_W-1:0]         z4_ff [3];
   logic signed [ZH_W+DIF_W-1:0]  pha4_ff [3];
   logic signed [ZH_W+DIF_W-1:0]  phb4_ff [3];
   logic signed [ZL_W+DIF_W:0]    pla4_ff [3];
   logic signed [ZL_W+DIF_W:0]    plb4_ff [3];
   logic                          deg4_ff;
   logic [PT_W-1:0]               cen4_ff [3];
   // stage 5
   logic signed [T_W-1:0]     x5_ff [3];
   logic signed [T_W-1:0]     y5_ff [3];
   logic signed [T_W-1:0]     z5_ff [3];
   logic                      deg5_ff;
   logic [PT_W-1:0]           cen5_ff [3];

   logic [CSUM_W-1:0]   cmag [3];
   logic [2*CN_W-1:0]   cprod [3];

   // ---------------- handshake ----------------
   always_comb begin
      take      = vld_ff[NST-1] && !out_stall;
      release_w = take && (deg5_ff || cnt_ff == COL_CEN);
      go[NST-1] = !vld_ff[NST-1] || release_w;
      for (int k = NST - 2; k >= 0; k--) begin
         go[k] = !vld_ff[k] || go[k+1];
      end
      in_stall = !go[0];
      if (release_w) begin
         cnt_in = COL_X;
      end else if (take) begin
         cnt_in = cnt_ff + 2'd1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         cnt_ff <= COL_X;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (go[k]) begin
               vld_ff[k] <= (k == 0) ? in_valid : vld_ff[k-1];
            end
         end
         cnt_ff <= cnt_in;
      end
   end

   // ---------------- datapath ----------------
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cmag[i]  = cs1_ff[i][CSUM_W-1] ? CSUM_W'(-cs1_ff[i]) : CSUM_W'(cs1_ff[i]);
         cprod[i] = cn2_ff[i] * CEN_M;
      end
   end

   always_ff @(posedge clock) begin
      if (go[0]) begin
         x1_ff[0] <= $signed({in_data.b_x[PT_W-1], in_data.b_x})
                   - $signed({in_data.a_x[PT_W-1], in_data.a_x});
         x1_ff[1] <= $signed({in_data.b_y[PT_W-1], in_data.b_y})
                   - $signed({in_data.a_y[PT_W-1], in_data.a_y});
         x1_ff[2] <= $signed({in_data.b_z[PT_W-1], in_data.b_z})
                   - $signed({in_data.a_z[PT_W-1], in_data.a_z});
         y1_ff[0] <= $signed({in_data.c_x[PT_W-1], in_data.c_x})
                   - $signed({in_data.a_x[PT_W-1], in_data.a_x});
         y1_ff[1] <= $signed({in_data.c_y[PT_W-1], in_data.c_y})
                   - $signed({in_data.a_y[PT_W-1], in_data.a_y});
         y1_ff[2] <= $signed({in_data.c_z[PT_W-1], in_data.c_z})
                   - $signed({in_data.a_z[PT_W-1], in_data.a_z});
         cs1_ff[0] <= CSUM_W'(in_data.a_x) + CSUM_W'(in_data.b_x)
                    + CSUM_W'(in_data.c_x);
         cs1_ff[1] <= CSUM_W'(in_data.a_y) + CSUM_W'(in_data.b_y)
                    + CSUM_W'(in_data.c_y);
         cs1_ff[2] <= CSUM_W'(in_data.a_z) + CSUM_W'(in_data.b_z)
                    + CSUM_W'(in_data.c_z);
      end
      if (go[1]) begin
         x2_ff     <= x1_ff;
         pa2_ff[0] <= x1_ff[1] * y1_ff[2];
         pb2_ff[0] <= x1_ff[2] * y1_ff[1];
         pa2_ff[1] <= x1_ff[2] * y1_ff[0];
         pb2_ff[1] <= x1_ff[0] * y1_ff[2];
         pa2_ff[2] <= x1_ff[0] * y1_ff[1];
         pb2_ff[2] <= x1_ff[1] * y1_ff[0];
         for (int i = 0; i < 3; i++) begin
            cn2_ff[i]   <= CN_W'(cmag[i]) + CN_W'(1);
            cneg2_ff[i] <= cs1_ff[i][CSUM_W-1];
         end
      end
      if (go[2]) begin
         x3_ff <= x2_ff;
         for (int i = 0; i < 3; i++) begin
            z3_ff[i]  <= Z_W'(pa2_ff[i]) - Z_W'(pb2_ff[i]);
            cq3_ff[i] <= cprod[i][CEN_K+PT_W-1:CEN_K];
         end
         cneg3_ff <= cneg2_ff;
      end
      if (go[3]) begin
         x4_ff <= x3_ff;
         z4_ff <= z3_ff;
         for (int i = 0; i < 3; i++) begin
            // y_i = z_j x_k - z_k x_j, z split into signed high and unsigned low
            pha4_ff[i] <= $signed(z3_ff[(i == 2) ? 0 : i + 1][Z_W-1:ZL_W])
                        * x3_ff[(i == 0) ? 2 : i - 1];
            pla4_ff[i] <= $signed({1'b0, z3_ff[(i == 2) ? 0 : i + 1][ZL_W-1:0]})
                        * x3_ff[(i == 0) ? 2 : i - 1];
            phb4_ff[i] <= $signed(z3_ff[(i == 0) ? 2 : i - 1][Z_W-1:ZL_W])
                        * x3_ff[(i == 2) ? 0 : i + 1];
            plb4_ff[i] <= $signed({1'b0, z3_ff[(i == 0) ? 2 : i - 1][ZL_W-1:0]})
                        * x3_ff[(i == 2) ? 0 : i + 1];
            cen4_ff[i] <= cneg3_ff[i] ? -cq3_ff[i] : cq3_ff[i];
         end
         // z is zero exactly when some axis has zero length
         deg4_ff <= (z3_ff[0] == '0) && (z3_ff[1] == '0) && (z3_ff[2] == '0);
      end
      if (go[4]) begin
         for (int i = 0; i < 3; i++) begin
            x5_ff[i] <= T_W'(x4_ff[i]);
            z5_ff[i] <= T_W'(z4_ff[i]);
            y5_ff[i] <= (T_W'(pha4_ff[i]) <<< ZL_W) + T_W'(pla4_ff[i])
                      - (T_W'(phb4_ff[i]) <<< ZL_W) - T_W'(plb4_ff[i]);
         end
         deg5_ff <= deg4_ff;
         cen5_ff <= cen4_ff;
      end
   end

   // ---------------- column sequencer ----------------
   always_comb begin
      out_valid    = vld_ff[NST-1];
      out_data.sel = deg5_ff ? COL_X : cnt_ff;
      out_data.deg = deg5_ff;
      out_data.cen = (cnt_ff == COL_CEN);
      out_data.lst = deg5_ff || (cnt_ff == COL_CEN);
      for (int i = 0; i < 3; i++) begin
         unique case (cnt_ff)
            COL_X:   out_data.val[i] = x5_ff[i];
            COL_Y:   out_data.val[i] = y5_ff[i];
            COL_Z:   out_data.val[i] = z5_ff[i];
            COL_CEN: out_data.val[i] = T_W'($signed(cen5_ff[i]));
            default: out_data.val[i] = x5_ff[i];
         endcase
      end
   end

endmodule

// ===== design/ofr_square.sv =====
// ----------------------------------------------------------------------------
// ofr_square: component magnitudes and their exact squares
// Four stages: sign and magnitude, chunk partial products, row sums and the
// full square, three lanes side by side.
// ----------------------------------------------------------------------------
module ofr_square (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  ofr_pkg::col_word_type in_data,
   output logic                 out_valid,
   input  logic                 out_stall,
   output ofr_pkg::sq_word_type  out_data
);
   import ofr_pkg::*;

   localparam int NST = 4;

   logic [NST-1:0] vld_ff;
   logic [NST-1:0] go;

   col_meta_type     meta0_in;
   col_meta_type     meta_ff [NST-1];
   logic [MAG_W-1:0] mag0_in [3];
   logic [MAG_W-1:0] mag0_ff [3];
   logic [PP_W-1:0]  pp1_ff [3][N_CH][N_CH];
   logic [ROW_W-1:0] row2_in [3][N_CH];
   logic [ROW_W-1:0] row2_ff [3][N_CH];
   logic [SQ_W-1:0]  sq3_in [3];
   sq_word_type      out_ff;

   always_comb begin
      go[NST-1] = !vld_ff[NST-1] || !out_stall;
      for (int k = NST - 2; k >= 0; k--) begin
         go[k] = !vld_ff[k] || go[k+1];
      end
      in_stall  = !go[0];
      out_valid = vld_ff[NST-1];
      out_data  = out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (go[k]) begin
               vld_ff[k] <= (k == 0) ? in_valid : vld_ff[k-1];
            end
         end
      end
   end

   always_comb begin
      logic [T_W-1:0] absv;
      meta0_in.sel = in_data.sel;
      meta0_in.deg = in_data.deg;
      meta0_in.cen = in_data.cen;
      meta0_in.lst = in_data.lst;
      for (int i = 0; i < 3; i++) begin
         meta0_in.neg[i]  = in_data.val[i][T_W-1];
         meta0_in.cval[i] = in_data.val[i][PT_W-1:0];
         absv = in_data.val[i][T_W-1] ? (~in_data.val[i] + T_W'(1)) : in_data.val[i];
         mag0_in[i] = absv[MAG_W-1:0];
      end
   end

   always_comb begin
      logic [SQ_W-1:0] acc;
      for (int l = 0; l < 3; l++) begin
         for (int i = 0; i < N_CH; i++) begin
            row2_in[l][i] = '0;
            for (int j = 0; j < N_CH; j++) begin
               row2_in[l][i] = row2_in[l][i] + (ROW_W'(pp1_ff[l][i][j]) << (CH_W * j));
            end
         end
         acc = '0;
         for (int i = 0; i < N_CH; i++) begin
            acc = acc + (SQ_W'(row2_ff[l][i]) << (CH_W * i));
         end
         sq3_in[l] = acc;
      end
   end

   always_ff @(posedge clock) begin
      if (go[0]) begin
         meta_ff[0] <= meta0_in;
         mag0_ff    <= mag0_in;
      end
      if (go[1]) begin
         meta_ff[1] <= meta_ff[0];
         for (int l = 0; l < 3; l++) begin
            for (int i = 0; i < N_CH; i++) begin
               for (int j = 0; j < N_CH; j++) begin
                  pp1_ff[l][i][j] <= mag0_ff[l][CH_W*i +: CH_W] * mag0_ff[l][CH_W*j +: CH_W];
               end
            end
         end
      end
      if (go[2]) begin
         meta_ff[2] <= meta_ff[1];
         row2_ff    <= row2_in;
      end
      if (go[3]) begin
         out_ff.meta <= meta_ff[2];
         for (int l = 0; l < 3; l++) begin
            out_ff.sq[l] <= sq3_in[l];
         end
      end
   end

endmodule

// ===== design/ofr_unit.sv =====
// ----------------------------------------------------------------------------
// ofr_unit: unit components by exact bit recurrence
// One stage forms |v|^2 and the scaled targets, then one stage per result bit
// decides v = floor(2|t|2^F/|v|); the output stage rounds and signs it.
// ----------------------------------------------------------------------------
module ofr_unit #(
   parameter int FRAC_BITS = ofr_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  ofr_pkg::sq_word_type  in_data,
   output logic                 out_valid,
   input  logic                 out_stall,
   output ofr_pkg::rsp_word_type out_data
);
   import ofr_pkg::*;

   localparam int NB  = FRAC_BITS + 2;             // bits of the trial root
   localparam int CW  = S_W + 2 * FRAC_BITS + 5;   // residual width
   localparam int PWU = S_W + FRAC_BITS + 2;       // root times |v|^2
   localparam int NST = NB + 2;

   logic [NST-1:0]   vld_ff;
   logic [NST-1:0]   go;

   col_meta_type     meta_ff [NB+1];
   logic [S_W-1:0]   s_ff [NB];
   logic [CW-1:0]    e_ff [NB][3];
   logic [PWU-1:0]   p_ff [1:NB-1][3];
   logic [NB-1:0]    v_ff [1:NB][3];
   rsp_word_type     out_ff;
   rsp_word_type     out_in;

   always_comb begin
      go[NST-1] = !vld_ff[NST-1] || !out_stall;
      for (int k = NST - 2; k >= 0; k--) begin
         go[k] = !vld_ff[k] || go[k+1];
      end
      in_stall  = !go[0];
      out_valid = vld_ff[NST-1];
      out_data  = out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (go[k]) begin
               vld_ff[k] <= (k == 0) ? in_valid : vld_ff[k-1];
            end
         end
      end
   end

   // stage 0: squared length and scaled targets 4 t^2 2^(2F)
   always_ff @(posedge clock) begin
      if (go[0]) begin
         meta_ff[0] <= in_data.meta;
         s_ff[0]    <= S_W'(in_data.sq[0]) + S_W'(in_data.sq[1]) + S_W'(in_data.sq[2]);
         for (int i = 0; i < 3; i++) begin
            e_ff[0][i] <= CW'(in_data.sq[i]) << (2 * FRAC_BITS + 2);
         end
      end
   end

   for (genvar k = 1; k <= NB; k++) begin : g_bit
      localparam int B = NB - k;

      logic [CW-1:0]  e_prev [3];
      logic [PWU-1:0] p_prev [3];
      logic [NB-1:0]  v_prev [3];
      logic [CW-1:0]  trial [3];
      logic [2:0]     pass;
      logic [CW-1:0]  e_in [3];
      logic [PWU-1:0] p_in [3];
      logic [NB-1:0]  v_in [3];

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            e_prev[i] = e_ff[k-1][i];
            if (k == 1) begin
               p_prev[i] = '0;
               v_prev[i] = '0;
            end else begin
               p_prev[i] = p_ff[(k == 1) ? 1 : k-1][i];
               v_prev[i] = v_ff[(k == 1) ? 1 : k-1][i];
            end
            // (v + 2^B)^2 s - v^2 s
            trial[i] = (CW'(p_prev[i]) << (B + 1)) + (CW'(s_ff[k-1]) << (2 * B));
            pass[i]  = (trial[i] <= e_prev[i]);
            e_in[i]  = pass[i] ? e_prev[i] - trial[i] : e_prev[i];
            p_in[i]  = pass[i] ? p_prev[i] + (PWU'(s_ff[k-1]) << B) : p_prev[i];
            v_in[i]  = pass[i] ? (v_prev[i] | (NB'(1) << B)) : v_prev[i];
         end
      end

      always_ff @(posedge clock) begin
         if (go[k]) begin
            meta_ff[k] <= meta_ff[k-1];
            v_ff[k]    <= v_in;
         end
      end

      if (k < NB) begin : g_carry
         always_ff @(posedge clock) begin
            if (go[k]) begin
               s_ff[k] <= s_ff[k-1];
               e_ff[k] <= e_in;
               p_ff[k] <= p_in;
            end
         end
      end
   end

   // round half up on the root: m = ceil(v/2), then apply the sign
   always_comb begin
      logic [NB:0]     vp1;
      logic [PT_W-1:0] mag;
      logic [PT_W-1:0] vec [3];
      for (int i = 0; i < 3; i++) begin
         vp1 = {1'b0, v_ff[NB][i]} + (NB + 1)'(1);
         mag = PT_W'(vp1[NB:1]);
         if (meta_ff[NB].deg) begin
            vec[i] = '0;
         end else if (meta_ff[NB].cen) begin
            vec[i] = meta_ff[NB].cval[i];
         end else begin
            vec[i] = meta_ff[NB].neg[i] ? -mag : mag;
         end
      end
      out_in.column_sel = meta_ff[NB].deg ? COL_X : meta_ff[NB].sel;
      out_in.vec_x      = vec[0];
      out_in.vec_y      = vec[1];
      out_in.vec_z      = vec[2];
      out_in.ok         = !meta_ff[NB].deg;
      out_in.last       = meta_ff[NB].lst;
   end

   always_ff @(posedge clock) begin
      if (go[NST-1]) begin
         out_ff <= out_in;
      end
   end

`ifndef SYNTHESIS
   a_deg_single: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_data.ok |-> out_data.last && out_data.column_sel == COL_X)
      else $error("degenerate word is not a lone x column");

   a_last_on_cen: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_data.ok |-> out_data.last == (out_data.column_sel == COL_CEN))
      else $error("last flag does not match centroid column");

   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NB] && meta_ff[NB].deg && go[NST-1] |=>
         out_data.vec_x == 0 && out_data.vec_y == 0 && out_data.vec_z == 0)
      else $error("degenerate word carries nonzero vector");
`endif

endmodule

// ===== design/orthonormal_frame_from_three_points_unit.sv =====
// ----------------------------------------------------------------------------
// orthonormal_frame_from_three_points_unit: frame from a triangle
// Builds unit x, y, z axes and the centroid of three Q16.16 points.
//
//   channel  dir  payload          words per triangle
//   req_     in   req_word_type    1
//   rsp_     out  rsp_word_type    4, or 1 when the points are degenerate
//
// A triangle passes through the front pipe; its columns then issue one a
// cycle into the normalize pipe while it does not stall, four per triangle
// (one if degenerate).
// Reset clears the valid bits and the column counter only.
// A stalled rsp_ backs up stage by stage; empty stages keep filling.
// ----------------------------------------------------------------------------
module orthonormal_frame_from_three_points_unit #(
   parameter int FRAC_BITS = ofr_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ofr_pkg::req_word_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ofr_pkg::rsp_word_type rsp_data
);
   import ofr_pkg::*;

   logic         col_valid;
   logic         col_stall;
   col_word_type col_data;
   logic         sq_valid;
   logic         sq_stall;
   sq_word_type  sq_data;

   ofr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_data),
      .out_valid (col_valid),
      .out_stall (col_stall),
      .out_data  (col_data)
   );

   ofr_square u_square (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (col_valid),
      .in_stall  (col_stall),
      .in_data   (col_data),
      .out_valid (sq_valid),
      .out_stall (sq_stall),
      .out_data  (sq_data)
   );

   ofr_unit #(
      .FRAC_BITS (FRAC_BITS)
   ) u_unit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_stall  (sq_stall),
      .in_data   (sq_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

endmodule

// ===== sim/tb_orthonormal_frame_from_three_points_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_orthonormal_frame_from_three_points_unit: self-checking bench
// Drives triangles into the frame unit and checks every result word against
// an exact wide-integer model of the axes, their normalization and the
// centroid. The request channel idles and the response channel stalls at
// random, with one quiet stretch.
module tb_orthonormal_frame_from_three_points_unit;
   import ofr_pkg::*;

   localparam int FRAC    = FRAC_BITS_DEF;
   localparam int WW      = 300;
   localparam int N_RAND  = 258;

   typedef logic signed [WW-1:0] wide_t;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_word_type  req_data = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_word_type  rsp_data;

   req_word_type  tri_q[$];
   rsp_word_type  frame_q[$];
   int            n_sent = 0;
   int            n_words = 0;
   int            n_frames = 0;
   int            n_degen = 0;
   int            n_err = 0;
   bit            req_took = 1'b0;

   orthonormal_frame_from_three_points_unit #(.FRAC_BITS(FRAC)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // round(c * 2^FRAC / sqrt(s)), ties away from zero, by bisection
   function automatic logic signed [PT_W-1:0] unit_component(wide_t c, wide_t s);
      bit             neg;
      wide_t          t;
      wide_t          rhs;
      wide_t          osq;
      longint         lo;
      longint         hi;
      longint         mid;
      longint         o;
      neg = c < 0;
      t = neg ? -c : c;
      rhs = (t * t) <<< (2 * FRAC + 2);
      lo = 0;
      hi = longint'(1) << FRAC;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         o = 2 * mid - 1;
         osq = o * o;
         if (osq * s <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return PT_W'(neg ? -lo : lo);
   endfunction

   function automatic logic signed [PT_W-1:0] centroid_third(longint s);
      if (s >= 0) return PT_W'((s + 1) / 3);
      return PT_W'(-((-s + 1) / 3));
   endfunction

   task automatic predict_frame(req_word_type w);
      wide_t        pa[3];
      wide_t        pb[3];
      wide_t        pc[3];
      wide_t        ax[3][3];
      wide_t        y0[3];
      wide_t        nsq[3];
      rsp_word_type r;
      logic [1:0]   cols[4];
      longint       sum;
      cols = '{COL_X, COL_Y, COL_Z, COL_CEN};
      pa = '{w.a_x, w.a_y, w.a_z};
      pb = '{w.b_x, w.b_y, w.b_z};
      pc = '{w.c_x, w.c_y, w.c_z};
      for (int i = 0; i < 3; i++) begin
         ax[0][i] = pb[i] - pa[i];
         y0[i] = pc[i] - pa[i];
      end
      ax[2][0] = ax[0][1] * y0[2] - ax[0][2] * y0[1];
      ax[2][1] = ax[0][2] * y0[0] - ax[0][0] * y0[2];
      ax[2][2] = ax[0][0] * y0[1] - ax[0][1] * y0[0];
      ax[1][0] = ax[2][1] * ax[0][2] - ax[2][2] * ax[0][1];
      ax[1][1] = ax[2][2] * ax[0][0] - ax[2][0] * ax[0][2];
      ax[1][2] = ax[2][0] * ax[0][1] - ax[2][1] * ax[0][0];
      for (int k = 0; k < 3; k++)
         nsq[k] = ax[k][0] * ax[k][0] + ax[k][1] * ax[k][1] + ax[k][2] * ax[k][2];
      if (nsq[0] == 0 || nsq[1] == 0 || nsq[2] == 0) begin
         r = '0;
         r.column_sel = COL_X;
         r.last = 1'b1;
         frame_q.push_back(r);
         n_degen++;
         return;
      end
      for (int k = 0; k < 4; k++) begin
         r = '0;
         r.column_sel = cols[k];
         r.ok = 1'b1;
         r.last = (k == 3);
         if (k < 3) begin
            r.vec_x = unit_component(ax[k][0], nsq[k]);
            r.vec_y = unit_component(ax[k][1], nsq[k]);
            r.vec_z = unit_component(ax[k][2], nsq[k]);
         end else begin
            sum = longint'(w.a_x) + longint'(w.b_x) + longint'(w.c_x);
            r.vec_x = centroid_third(sum);
            sum = longint'(w.a_y) + longint'(w.b_y) + longint'(w.c_y);
            r.vec_y = centroid_third(sum);
            sum = longint'(w.a_z) + longint'(w.b_z) + longint'(w.c_z);
            r.vec_z = centroid_third(sum);
         end
         frame_q.push_back(r);
      end
      n_frames++;
   endtask

   function automatic req_word_type mk(int ax, int ay, int az, int bx, int by,
                                       int bz, int cx, int cy, int cz);
      req_word_type w;
      w = '{ax, ay, az, bx, by, bz, cx, cy, cz};
      return w;
   endfunction

   function automatic int rnd_small();
      return int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
   endfunction

   function automatic bit quiet();
      return n_sent >= 110 && n_sent < 170;
   endfunction

   // monitor: sample both handshakes at the rising edge
   always @(posedge clock) begin
      req_took = !reset && req_valid && !req_stall;
      if (req_took) predict_frame(req_data);
      if (!reset && rsp_valid && !rsp_stall) begin
         n_words++;
         if (frame_q.size() == 0) begin
            $display("%0t: unexpected word %p", $time, rsp_data);
            n_err++;
         end else begin
            if (rsp_data !== frame_q[0])
               $display("%0t: mismatch expected %p actual %p", $time, frame_q[0], rsp_data);
            if (rsp_data.column_sel !== frame_q[0].column_sel ||
                rsp_data.vec_x !== frame_q[0].vec_x ||
                rsp_data.vec_y !== frame_q[0].vec_y ||
                rsp_data.vec_z !== frame_q[0].vec_z ||
                rsp_data.ok !== frame_q[0].ok ||
                rsp_data.last !== frame_q[0].last)
               n_err++;
            void'(frame_q.pop_front());
         end
      end
   end

   // driver: change inputs at the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         rsp_stall <= !quiet() && ($urandom_range(0, 99) < 18);
         if (!req_valid || req_took) begin
            if (tri_q.size() != 0 && (quiet() || $urandom_range(0, 99) >= 18)) begin
               req_valid <= 1'b1;
               req_data <= tri_q.pop_front();
               n_sent++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   initial begin
      int           a[9];
      int           k;
      int unsigned  mode;
      tri_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
      tri_q.push_back(mk(5, 6, 7, 5, 6, 7, 9, 1, 2));
      tri_q.push_back(mk(1, 2, 3, 4, 6, 8, 7, 10, 13));
      tri_q.push_back(mk(0, 0, 0, 65536, 0, 0, 0, 65536, 0));
      tri_q.push_back(mk(0, 0, 0, 0, 0, 65536, 65536, 0, 0));
      tri_q.push_back(mk(0, 0, 0, 1, 0, 0, 0, 1, 0));
      tri_q.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000,
                         32'h7fffffff, 32'h7fffffff, 32'h80000000,
                         32'h7fffffff, 32'h80000000, 32'h7fffffff));
      tri_q.push_back(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                         32'h80000000, 32'h7fffffff, 32'h7fffffff,
                         32'h7fffffff, 32'h80000000, 32'h80000000));
      tri_q.push_back(mk(32'h80000000, 0, 32'h7fffffff, 32'h7fffffff, 0,
                         32'h80000000, 0, 32'h7fffffff, 0));
      tri_q.push_back(mk(-1, -1, -1, -2, -1, -1, -1, -2, -1));
      tri_q.push_back(mk(-7, 3, 100, 2, -5, 100, 11, 40, -9));
      tri_q.push_back(mk(0, 0, 0, 65536, 65536, 0, 131072, 0, 65536));
      tri_q.push_back(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                         32'h7fffffff, 32'h7fffffff, 0, 0, 0));
      for (int n = 0; n < N_RAND; n++) begin
         mode = $urandom_range(0, 9);
         for (int i = 0; i < 9; i++) a[i] = (mode < 5) ? int'($urandom()) : rnd_small();
         if (mode == 9) begin
            // collinear or coincident points
            k = $urandom_range(0, 3) - 1;
            for (int i = 0; i < 3; i++) a[6 + i] = a[i] + k * (a[3 + i] - a[i]);
         end
         tri_q.push_back(mk(a[0], a[1], a[2], a[3], a[4], a[5], a[6], a[7], a[8]));
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (tri_q.size() == 0);
      @(posedge clock);
      wait (!req_valid && frame_q.size() == 0);
      repeat (60) @(posedge clock);
      $display("triangles sent %0d: %0d full frames, %0d degenerate; %0d words checked",
               n_sent, n_frames, n_degen, n_words);
      if (n_err == 0 && frame_q.size() == 0) begin
         $display("[orthonormal_frame_from_three_points_unit] OK");
      end else begin
         $display("%0d failures, %0d words outstanding", n_err, frame_q.size());
         $display("[orthonormal_frame_from_three_points_unit] ERROR");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("timeout at %0t", $time);
      $display("[orthonormal_frame_from_three_points_unit] ERROR");
      $finish;
   end

endmodule
